@@ sv/imm_pkg.sv @@
package imm_pkg;

  // Array geometry and arithmetic widths
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int SUM_W      = 36;

  // Item modes
  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_MUL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             col_index;
    logic signed [ELEM_WIDTH-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [SUM_W-1:0] dot_sum;
    logic                    last_element;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             tail;
    logic             fin;
    logic [IDX_W-1:0] ri;
    logic [IDX_W-1:0] rj;
    logic [IDX_W-1:0] rk;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;
    logic done;
  } dp_status_t;

endpackage

@@ sv/imm_datapath.sv @@
module imm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  imm_pkg::ctl_cmd_t   cmd,
  input  imm_pkg::in_item_t   item,
  output imm_pkg::dp_status_t status,
  output imm_pkg::out_item_t  result,
  output logic                result_valid
);
  import imm_pkg::*;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;

  // stage 1: operand reads
  logic signed [ELEM_WIDTH-1:0] a_q;
  logic signed [ELEM_WIDTH-1:0] b_q;
  logic                         s1_vld;
  logic                         s1_first, s1_tail, s1_fin;
  logic [IDX_W-1:0]             s1_i, s1_j;

  // stage 2: product
  logic signed [PROD_W-1:0]     prod;
  logic                         s2_vld;
  logic                         s2_first, s2_tail, s2_fin;
  logic [IDX_W-1:0]             s2_i, s2_j;

  // stage 3: accumulator
  logic signed [SUM_W-1:0]      acc;
  logic signed [SUM_W-1:0]      acc_next;

  assign wr_addr   = {item.row_index, item.col_index};
  assign rd_addr_a = {cmd.ri, cmd.rk};
  assign rd_addr_b = {cmd.rk, cmd.rj};

  // element stores, one write and one read port each
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= item.element_value;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= item.element_value;
    end
    a_q <= mem_a[rd_addr_a];
    b_q <= mem_b[rd_addr_b];
  end

  // stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.rd_en;
      s2_vld <= s1_vld;
    end
    s1_first <= cmd.first;
    s1_tail  <= cmd.tail;
    s1_fin   <= cmd.fin;
    s1_i     <= cmd.ri;
    s1_j     <= cmd.rj;
    s2_first <= s1_first;
    s2_tail  <= s1_tail;
    s2_fin   <= s1_fin;
    s2_i     <= s1_i;
    s2_j     <= s1_j;
  end

  // multiplier
  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
  end

  // accumulate; the first term of a dot product restarts the sum
  always_comb begin
    if (s2_first) begin
      acc_next = SUM_W'(prod);
    end else begin
      acc_next = acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld) begin
      acc <= acc_next;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_vld && s2_tail;
    end
    if (s2_vld && s2_tail) begin
      result.out_row      <= s2_i;
      result.out_col      <= s2_j;
      result.dot_sum      <= acc_next;
      result.last_element <= s2_fin;
    end
  end

  assign status.pipe_busy = s1_vld || s2_vld || result_valid;
  assign status.done      = result_valid && result.last_element;

  // stages move forward every cycle
  a_s1_moves: assert property (@(posedge clk) disable iff (rst) s1_vld |=> s2_vld)
    else $error("stage 1 item lost");

  // the final result is never followed at once by another one
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_element |=> !result_valid)
    else $error("result right after the final one");

endmodule

@@ sv/imm_control.sv @@
module imm_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  imm_pkg::in_item_t   item,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  imm_pkg::dp_status_t status,
  output logic                busy,
  output logic                cfg_ready,
  output imm_pkg::ctl_cmd_t   cmd
);
  import imm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;

  logic [DIM_W-1:0] rows_a, inner_len, cols_b;
  logic [IDX_W-1:0] p_last, n_last, q_last;
  logic [IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic             accept;
  logic             run_start;
  logic             k_end, j_end, i_end;

  // last index for a dimension; zero acts as one, large values saturate
  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - DIM_W'(1));
    end
    return r;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign run_start = accept && (item.mode == MODE_MUL);

  assign k_end = (k_cnt == n_last);
  assign j_end = (j_cnt == q_last);
  assign i_end = (i_cnt == p_last);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_len <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_LEN: inner_len <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // state transitions
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (run_start) state_next = ST_RUN;
      ST_RUN:   if (k_end && j_end && i_end) state_next = ST_DRAIN;
      ST_DRAIN: if (status.done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters: k innermost, then j, then i
  always_ff @(posedge clk) begin
    if (run_start) begin
      p_last <= last_idx(rows_a);
      n_last <= last_idx(inner_len);
      q_last <= last_idx(cols_b);
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
    end else if (state == ST_RUN) begin
      if (k_end) begin
        k_cnt <= '0;
        if (j_end) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + IDX_W'(1);
        end else begin
          j_cnt <= j_cnt + IDX_W'(1);
        end
      end else begin
        k_cnt <= k_cnt + IDX_W'(1);
      end
    end
  end

  // commands
  assign cmd.wr_a  = accept && (item.mode == MODE_WR_A);
  assign cmd.wr_b  = accept && (item.mode == MODE_WR_B);
  assign cmd.rd_en = (state == ST_RUN);
  assign cmd.first = (k_cnt == '0);
  assign cmd.tail  = k_end;
  assign cmd.fin   = i_end && j_end;
  assign cmd.ri    = i_cnt;
  assign cmd.rj    = j_cnt;
  assign cmd.rk    = k_cnt;

  // the final result only arrives once issue has finished
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == ST_DRAIN)
    else $error("final result outside drain");

  // busy rises only for an accepted multiply
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(item.mode) == MODE_MUL)
    else $error("busy without a multiply start");

  // an idle block has an empty pipeline
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !status.pipe_busy)
    else $error("pipeline active while idle");

  // inner counter stays within the latched length
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> k_cnt <= n_last)
    else $error("inner counter out of range");

endmodule

@@ sv/integer_matrix_multiply.sv @@
// Channel   Handshake                      Payload
// item      start in / busy out            in_item_t: mode, row, col, element
// config    cfg_valid in / cfg_ready out   cfg_index (2 b), cfg_data (4 b)
// result    result_valid out (strobe)      out_item_t: row, col, dot_sum, last
//
// A write of an A or B element leaves busy low.
// A multiply issues one product per cycle on a single multiply-accumulate
// unit with one read port per store, rows_a * cols_b * inner_len products
// in all, which then pass the read, multiply and accumulate stages; busy
// falls the cycle after the final result strobe. Each result sums inner_len products.
// Synchronous reset clears control state; stores hold no reset value.
// The receiver cannot stall: each result is shown for one cycle only.
module integer_matrix_multiply (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  imm_pkg::in_item_t  item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output imm_pkg::out_item_t result,
  output logic               result_valid
);
  import imm_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  imm_control u_control (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  imm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

@@ bench/imm_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, config and result channels of the matrix multiplier.
// Keeps its own copy of both stores and the three dimension registers,
// expands each multiply into the expected C elements, and compares every
// result strobe against the oldest one still due.
module imm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  imm_pkg::in_item_t  item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  imm_pkg::out_item_t result,
  input  logic               result_valid,
  output int                 due_count,
  output int                 mismatch_count
);
  import imm_pkg::*;

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic [DIM_W-1:0]             rows_reg;
  logic [DIM_W-1:0]             inner_reg;
  logic [DIM_W-1:0]             cols_reg;
  out_item_t                    c_due [$];
  int                           fails;

  // register value to the dimension it selects: 0 acts as 1, above MAX_DIM clamps
  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // queue every element of C = A x B in row-major order
  task automatic push_products();
    int                      p;
    int                      n;
    int                      q;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] fa;
    logic signed [SUM_W-1:0] fb;
    out_item_t               e;
    p = eff_dim(rows_reg);
    n = eff_dim(inner_reg);
    q = eff_dim(cols_reg);
    for (int i = 0; i < p; i++) begin
      for (int j = 0; j < q; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          fa  = a_mem[ADDR_W'(i*MAX_DIM + k)];
          fb  = b_mem[ADDR_W'(k*MAX_DIM + j)];
          acc = acc + fa * fb;
        end
        e.out_row      = IDX_W'(i);
        e.out_col      = IDX_W'(j);
        e.dot_sum      = acc;
        e.last_element = (i == p - 1) && (j == q - 1);
        c_due.push_back(e);
      end
    end
  endtask

  // field-by-field compare against the oldest due element
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (c_due.size() == 0) begin
      $error("unexpected result: out_row %0d out_col %0d dot_sum %0d last_element %0b",
             got.out_row, got.out_col, got.dot_sum, got.last_element);
      fails++;
      return;
    end
    want = c_due.pop_front();
    if (got.out_row !== want.out_row) begin
      $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
      fails++;
    end
    if (got.out_col !== want.out_col) begin
      $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
      fails++;
    end
    if (got.dot_sum !== want.dot_sum) begin
      $error("dot_sum: expected %0d, actual %0d", want.dot_sum, got.dot_sum);
      fails++;
    end
    if (got.last_element !== want.last_element) begin
      $error("last_element: expected %0b, actual %0b", want.last_element, got.last_element);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg  = 4'd8;
      inner_reg = 4'd8;
      cols_reg  = 4'd8;
      c_due.delete();
    end else begin
      // config transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_A:    rows_reg  = cfg_data;
          REG_INNER_LEN: inner_reg = cfg_data;
          REG_COLS_B:    cols_reg  = cfg_data;
          default: ;
        endcase
      end
      // item transaction
      if (start && !busy) begin
        case (item.mode)
          MODE_WR_A: a_mem[{item.row_index, item.col_index}] = item.element_value;
          MODE_WR_B: b_mem[{item.row_index, item.col_index}] = item.element_value;
          MODE_MUL:  push_products();
          default: ;
        endcase
      end
      // result strobe
      if (result_valid) check_result(result);
    end
    due_count      <= c_due.size();
    mismatch_count <= fails;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import imm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE    = 2'd3;
  localparam int         ITEM_GOAL   = 310;
  localparam int         CALM_AFTER  = 270;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  item      = '0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data  = '0;
  out_item_t result;
  logic      result_valid;
  int        due_count;
  int        mismatch_count;

  // stimulus bookkeeping
  bit        wa [DEPTH];
  bit        wb [DEPTH];
  int        cur_p = MAX_DIM;
  int        cur_n = MAX_DIM;
  int        cur_q = MAX_DIM;
  int        items_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_matrix_multiply u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

  imm_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result         (result),
    .result_valid   (result_valid),
    .due_count      (due_count),
    .mismatch_count (mismatch_count)
  );

  // element values lean on the extremes
  function automatic logic [ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  // mostly small dimensions, now and then up to the maximum
  function automatic int pick_dim();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(4, MAX_DIM);
  endfunction

  // register encoding for a dimension; out-of-range codes alias 1 and MAX_DIM
  function automatic logic [DIM_W-1:0] pick_raw(int d, bit outer);
    if (d == 1 && (outer || $urandom_range(0, 3) == 0)) return '0;
    if (d == MAX_DIM && outer) return 4'd15;
    if (d == MAX_DIM && $urandom_range(0, 2) == 0) return DIM_W'($urandom_range(9, 15));
    return DIM_W'(d);
  endfunction

  task automatic hold_items(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one item and wait for its transaction; start stays high afterwards
  task automatic send_item(logic [1:0] m, int r, int c, logic [ELEM_WIDTH-1:0] v);
    in_item_t it;
    if (items_done < CALM_AFTER && $urandom_range(0, 4) == 0)
      hold_items($urandom_range(1, 18));
    it.mode          = m;
    it.row_index     = IDX_W'(r);
    it.col_index     = IDX_W'(c);
    it.element_value = v;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (m == MODE_WR_A) wa[ADDR_W'(r*MAX_DIM + c)] = 1'b1;
    if (m == MODE_WR_B) wb[ADDR_W'(r*MAX_DIM + c)] = 1'b1;
    if (m != MODE_UNUSED) items_done++;
  endtask

  task automatic send_mul();
    send_item(MODE_MUL, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_WIDTH'($urandom));
  endtask

  // stop offering and wait until no result is due and the block is idle
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (busy || due_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(int p, int n, int q, bit outer);
    wait_drain();
    if (outer || $urandom_range(0, 3) == 0) write_cfg(REG_NONE, DIM_W'($urandom));
    write_cfg(REG_ROWS_A, pick_raw(p, outer));
    write_cfg(REG_INNER_LEN, pick_raw(n, outer));
    write_cfg(REG_COLS_B, pick_raw(q, outer));
    cfg_valid <= 1'b0;
    cur_p = p;
    cur_n = n;
    cur_q = q;
  endtask

  // write every entry the next multiply reads that has never been written
  task automatic fill_needed();
    for (int i = 0; i < cur_p; i++)
      for (int k = 0; k < cur_n; k++)
        if (!wa[ADDR_W'(i*MAX_DIM + k)]) send_item(MODE_WR_A, i, k, pick_value());
    for (int k = 0; k < cur_n; k++)
      for (int j = 0; j < cur_q; j++)
        if (!wb[ADDR_W'(k*MAX_DIM + j)]) send_item(MODE_WR_B, k, j, pick_value());
  endtask

  initial begin : stimulus
    int nw;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait_drain();

    // full load and multiply at the reset dimensions
    fill_needed();
    send_mul();

    // 2x3 times 3x2 with extreme elements
    set_dims(2, 3, 2, 1'b0);
    send_item(MODE_WR_A, 0, 0, 16'h8000);
    send_item(MODE_WR_A, 0, 1, 16'h7fff);
    send_item(MODE_WR_A, 0, 2, 16'h8000);
    send_item(MODE_WR_A, 1, 0, 16'hffff);
    send_item(MODE_WR_A, 1, 1, 16'h0000);
    send_item(MODE_WR_A, 1, 2, 16'h0001);
    send_item(MODE_WR_B, 0, 0, 16'h8000);
    send_item(MODE_WR_B, 1, 0, 16'h7fff);
    send_item(MODE_WR_B, 2, 0, 16'h8000);
    send_item(MODE_WR_B, 0, 1, 16'h0001);
    send_item(MODE_WR_B, 1, 1, 16'hffff);
    send_item(MODE_WR_B, 2, 1, 16'h7fff);
    // unused mode must leave the stores alone
    send_item(MODE_UNUSED, 7, 7, ELEM_WIDTH'($urandom));
    send_mul();

    // zero codes act as 1, high codes clamp to the maximum
    set_dims(1, 1, 1, 1'b1);
    send_mul();
    set_dims(MAX_DIM, 1, MAX_DIM, 1'b1);
    send_item(MODE_WR_A, 7, 0, 16'h8000);
    send_item(MODE_WR_B, 0, 7, 16'h8000);
    send_mul();

    // random phases: mostly loads into the region read, then a multiply
    while (items_done < ITEM_GOAL) begin
      if ($urandom_range(0, 3) == 0)
        set_dims(pick_dim(), pick_dim(), pick_dim(), 1'b0);
      nw = $urandom_range(0, 6);
      repeat (nw) begin
        case ($urandom_range(0, 9))
          0: send_item(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                       ELEM_WIDTH'($urandom));
          1: send_item(MODE_WR_A, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
          2: send_item(MODE_WR_B, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
          3, 4, 5: send_item(MODE_WR_A, $urandom_range(0, cur_p - 1),
                             $urandom_range(0, cur_n - 1), pick_value());
          default: send_item(MODE_WR_B, $urandom_range(0, cur_n - 1),
                             $urandom_range(0, cur_q - 1), pick_value());
        endcase
      end
      fill_needed();
      if ($urandom_range(0, 5) == 0) wait_drain();
      send_mul();
    end

    wait_drain();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("** integer_matrix_multiply: PASSED **");
    end else begin
      $display("** integer_matrix_multiply: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("** integer_matrix_multiply: FAILED **");
    $finish;
  end

endmodule
